// File: rtl/sha1bc_pkg.sv
// Shared types, constants and round functions of the SHA-1 compression unit.
package sha1bc_pkg;

	localparam int BLOCK_WORDS  = 16;
	localparam int ROUNDS       = 80;
	localparam int DIGEST_WORDS = 5;
	localparam int POS_W        = $clog2(BLOCK_WORDS);
	localparam int RND_W        = $clog2(ROUNDS);
	localparam int IDX_W        = $clog2(DIGEST_WORDS);

	typedef logic [31:0] word_t;

	localparam word_t IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	typedef struct packed {
		logic [31:0] msg_word;
		logic        new_message;
		logic        final_block;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_item_t;

	// Control from the sequencer to the schedule buffer.
	typedef struct packed {
		logic  load;
		logic  step;
		word_t word;
	} sched_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	function automatic word_t round_k(input logic [RND_W-1:0] r);
		word_t k;
		if (r < RND_W'(20))
			k = K0;
		else if (r < RND_W'(40))
			k = K1;
		else if (r < RND_W'(60))
			k = K2;
		else
			k = K3;
		return k;
	endfunction

	function automatic word_t round_f(input logic [RND_W-1:0] r,
			input word_t b, input word_t c, input word_t d);
		word_t f;
		if (r < RND_W'(20))
			f = (b & c) | (~b & d);
		else if (r < RND_W'(40))
			f = b ^ c ^ d;
		else if (r < RND_W'(60))
			f = (b & c) | (b & d) | (c & d);
		else
			f = b ^ c ^ d;
		return f;
	endfunction

endpackage

// File: rtl/sha1bc_sched.sv
// Sixteen-word message schedule window: loads block words and expands W[t] in place.
module sha1bc_sched (
	input  logic                   clk,
	input  sha1bc_pkg::sched_ctl_t ctl,
	output sha1bc_pkg::word_t      w_cur
);

	sha1bc_pkg::word_t w_q [sha1bc_pkg::BLOCK_WORDS];
	sha1bc_pkg::word_t mix;
	sha1bc_pkg::word_t w_next;

	// W[t+16] from the current window, W[t] sitting in slot 0
	assign mix    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_next = {mix[30:0], mix[31]};
	assign w_cur  = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < sha1bc_pkg::BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[sha1bc_pkg::BLOCK_WORDS - 1] <= ctl.load ? ctl.word : w_next;
		end
	end

endmodule

// File: rtl/sha1_block_compression_unit.sv
// Top level of the SHA-1 compression unit: word intake, round sequencer, digest output.
//
//   channel | direction | payload                                | handshake
//   in      | input     | msg_word, new_message, final_block     | in_valid / in_ready
//   out     | output    | digest_word, digest_last               | out_valid / out_ready
//
// Words are taken on the in handshake; the 16th word of a block starts 80 rounds on the
// single shared round adder, then ST_ADD adds the working words into the chaining words;
// after a final block five digest words are output. in_ready is low from the 16th word
// until the block is done and its digest, if any, has been taken. out_valid holds each
// digest word until out_ready. Reset loads the initial chaining value.
module sha1_block_compression_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha1bc_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha1bc_pkg::out_item_t out_data
);

	sha1bc_pkg::state_t                  state_q;
	logic [sha1bc_pkg::POS_W-1:0]        word_pos_q;
	logic [sha1bc_pkg::RND_W-1:0]        rnd_q;
	logic [sha1bc_pkg::IDX_W-1:0]        out_idx_q;
	logic                                final_q;
	sha1bc_pkg::word_t                   h_q [sha1bc_pkg::DIGEST_WORDS];
	sha1bc_pkg::word_t                   a_q, b_q, c_q, d_q, e_q;

	logic                                in_acc;
	logic [sha1bc_pkg::POS_W-1:0]        pos_eff;
	logic                                last_word;
	sha1bc_pkg::word_t                   w_cur;
	sha1bc_pkg::word_t                   t_sum;
	sha1bc_pkg::sched_ctl_t              sched_ctl;

	assign in_ready  = (state_q == sha1bc_pkg::ST_IDLE);
	assign out_valid = (state_q == sha1bc_pkg::ST_OUT);
	assign in_acc    = in_valid && in_ready;
	assign pos_eff   = in_data.new_message ? '0 : word_pos_q;
	assign last_word = (pos_eff == sha1bc_pkg::POS_W'(sha1bc_pkg::BLOCK_WORDS - 1));

	assign sched_ctl.load = in_acc;
	assign sched_ctl.step = (state_q == sha1bc_pkg::ST_ROUND);
	assign sched_ctl.word = in_data.msg_word;

	sha1bc_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	// Shared round unit
	assign t_sum = {a_q[26:0], a_q[31:27]}
		+ sha1bc_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + w_cur + sha1bc_pkg::round_k(rnd_q);

	assign out_data.digest_word = h_q[out_idx_q];
	assign out_data.digest_last = (out_idx_q == sha1bc_pkg::IDX_W'(sha1bc_pkg::DIGEST_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha1bc_pkg::ST_IDLE;
			word_pos_q <= '0;
			rnd_q      <= '0;
			out_idx_q  <= '0;
			final_q    <= 1'b0;
			for (int i = 0; i < sha1bc_pkg::DIGEST_WORDS; i++)
				h_q[i] <= sha1bc_pkg::IV[i];
		end else begin
			case (state_q)
				sha1bc_pkg::ST_IDLE: begin
					if (in_acc) begin
						// reload chaining value and restart the block
						if (in_data.new_message) begin
							for (int i = 0; i < sha1bc_pkg::DIGEST_WORDS; i++)
								h_q[i] <= sha1bc_pkg::IV[i];
						end
						if (last_word) begin
							word_pos_q <= '0;
							rnd_q      <= '0;
							final_q    <= in_data.final_block;
							state_q    <= sha1bc_pkg::ST_ROUND;
						end else begin
							word_pos_q <= pos_eff + 1'b1;
						end
					end
				end
				sha1bc_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == sha1bc_pkg::RND_W'(sha1bc_pkg::ROUNDS - 1))
						state_q <= sha1bc_pkg::ST_ADD;
				end
				sha1bc_pkg::ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					out_idx_q <= '0;
					state_q   <= final_q ? sha1bc_pkg::ST_OUT : sha1bc_pkg::ST_IDLE;
				end
				sha1bc_pkg::ST_OUT: begin
					if (out_ready) begin
						if (out_data.digest_last)
							state_q <= sha1bc_pkg::ST_IDLE;
						else
							out_idx_q <= out_idx_q + 1'b1;
					end
				end
				default: state_q <= sha1bc_pkg::ST_IDLE;
			endcase
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (in_acc && last_word) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == sha1bc_pkg::ST_ROUND) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && word_pos_q == sha1bc_pkg::POS_W'(sha1bc_pkg::BLOCK_WORDS - 1)
			&& !in_data.new_message) |=> !in_ready)
		else $error("16th word did not start compression");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bc_pkg::ST_ROUND) |-> (rnd_q < sha1bc_pkg::RND_W'(sha1bc_pkg::ROUNDS)))
		else $error("round counter out of range");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bc_pkg::ST_ADD && final_q) |=> (out_valid && out_idx_q == '0))
		else $error("final block did not start digest output");

endmodule
